// File: hw/rtl/subset_sum_dp_traceback_top_assert.svh
// ----------------------------------------------------------------------------
// subset sum engine assertion macros
// same-cycle and next-cycle implication checks on a sampled clock
// ----------------------------------------------------------------------------
`ifndef SUBSET_SUM_DP_TRACEBACK_TOP_ASSERT_SVH
`define SUBSET_SUM_DP_TRACEBACK_TOP_ASSERT_SVH

// same-cycle implication
`define SSDP_ASSERT_NOW(label, clk_s, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SSDP_ASSERT_NEXT(label, clk_s, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/ssdp_pkg.sv
// ----------------------------------------------------------------------------
// ssdp_pkg
// shared types and constants of the subset sum engine
// ----------------------------------------------------------------------------
package ssdp_pkg;

	localparam int VAL_W       = 16;
	localparam int IDX_W       = 7;
	localparam int SUM_W       = 10;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	typedef struct packed {
		logic [VAL_W-1:0] item_value;
		logic             is_last_item;
	} item_t;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] chosen_index;
		logic [VAL_W-1:0] chosen_value;
		logic             is_last_result;
	} res_t;

	// one classified transaction for the back end
	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic [IDX_W-1:0] index;
		logic             store;
		logic             run;
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_OUTER,
		ST_OUTER_RD,
		ST_JLOOP,
		ST_JVAL,
		ST_JTAB,
		ST_CHECK,
		ST_CHECK_RD,
		ST_TRACE,
		ST_TR_IDX,
		ST_TR_VAL,
		ST_EMIT
	} state_t;

endpackage

// File: hw/rtl/ssdp_queue.sv
// ----------------------------------------------------------------------------
// ssdp_queue
// short command queue between the front end and the back end
// ----------------------------------------------------------------------------
module ssdp_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ssdp_pkg::cmd_t push_cmd,
	input  logic          pop,
	output ssdp_pkg::cmd_t head,
	output logic          empty,
	output logic          full
);
	import ssdp_pkg::*;

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: hw/rtl/ssdp_front.sv
// ----------------------------------------------------------------------------
// ssdp_front
// accepts input transactions, numbers them and marks store and run
// ----------------------------------------------------------------------------
module ssdp_front #(
	parameter int MAX_ITEMS = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_stall,
	input  ssdp_pkg::item_t item_data,
	input  logic           q_full,
	output logic           push,
	output ssdp_pkg::cmd_t  push_cmd
);
	import ssdp_pkg::*;

	logic [IDX_W-1:0] count_q;
	logic             room;
	logic [IDX_W-1:0] n_next;

	assign item_stall = q_full;
	assign push       = item_valid && !q_full;
	assign room       = (count_q < IDX_W'(MAX_ITEMS));
	assign n_next     = room ? count_q + IDX_W'(1) : count_q;

	always_comb begin
		push_cmd.value = item_data.item_value;
		push_cmd.index = n_next;
		push_cmd.store = room;
		push_cmd.run   = item_data.is_last_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (push) begin
			count_q <= item_data.is_last_item ? '0 : n_next;
		end
	end

endmodule

// File: hw/rtl/ssdp_back.sv
// ----------------------------------------------------------------------------
// ssdp_back
// value store, table fill, traceback and result register
// ----------------------------------------------------------------------------
module ssdp_back #(
	parameter int MAX_ITEMS = 64,
	parameter int MAX_SUM   = 1023
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [ssdp_pkg::SUM_W-1:0]    target,
	input  ssdp_pkg::cmd_t                head,
	input  logic                          q_empty,
	output logic                          pop,
	output logic                          res_valid,
	input  logic                          res_stall,
	output ssdp_pkg::res_t                res_data
);
	import ssdp_pkg::*;

	localparam int TAB_DEPTH = ((MAX_SUM < 1023) ? MAX_SUM : 1023) + 1;
	localparam int TAB_AW    = $clog2(TAB_DEPTH);
	localparam int IDX_AW    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

	logic [VAL_W-1:0] vmem [MAX_ITEMS];
	logic [IDX_W-1:0] tab  [TAB_DEPTH];

	logic              v_we;
	logic [IDX_AW-1:0] v_waddr;
	logic [IDX_AW-1:0] v_raddr;
	logic [VAL_W-1:0]  v_rd_q;
	logic              tab_we;
	logic [TAB_AW-1:0] tab_waddr;
	logic [IDX_W-1:0]  tab_wdata;
	logic [TAB_AW-1:0] tab_raddr;
	logic [IDX_W-1:0]  tab_rd_q;

	state_t           state_q, state_d;
	logic [SUM_W-1:0] goal_q, goal_d;
	logic [IDX_W-1:0] n_q, n_d;
	logic [SUM_W-1:0] i_q, i_d;
	logic [IDX_W-1:0] j_q, j_d;
	logic [SUM_W-1:0] k_q, k_d;
	logic [SUM_W-1:0] sum_q, sum_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	res_t             pend_q, pend_d;
	logic             out_valid_q;
	res_t             out_q;
	logic             out_free;
	logic             out_load;
	logic [VAL_W:0]   k_wide;
	logic [SUM_W-1:0] new_sum;

	assign out_free  = !out_valid_q || !res_stall;
	assign res_valid = out_valid_q;
	assign res_data  = out_q;
	assign k_wide    = (VAL_W+1)'(i_q) + (VAL_W+1)'(v_rd_q);
	assign new_sum   = sum_q - v_rd_q[SUM_W-1:0];

	always_ff @(posedge clk) begin
		if (v_we) begin
			vmem[v_waddr] <= head.value;
		end
		v_rd_q <= vmem[v_raddr];
	end

	always_ff @(posedge clk) begin
		if (tab_we) begin
			tab[tab_waddr] <= tab_wdata;
		end
		tab_rd_q <= tab[tab_raddr];
	end

	always_comb begin
		state_d   = state_q;
		goal_d    = goal_q;
		n_d       = n_q;
		i_d       = i_q;
		j_d       = j_q;
		k_d       = k_q;
		sum_d     = sum_q;
		idx_d     = idx_q;
		pend_d    = pend_q;
		pop       = 1'b0;
		out_load  = 1'b0;
		v_we      = 1'b0;
		v_waddr   = IDX_AW'(head.index - IDX_W'(1));
		v_raddr   = IDX_AW'(j_q - IDX_W'(1));
		tab_we    = 1'b0;
		tab_waddr = i_q[TAB_AW-1:0];
		tab_wdata = '0;
		tab_raddr = i_q[TAB_AW-1:0];
		case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					pop  = 1'b1;
					v_we = head.store;
					if (head.run) begin
						n_d     = head.index;
						goal_d  = (int'(target) > MAX_SUM) ? SUM_W'(MAX_SUM) : target;
						i_d     = '0;
						state_d = ST_CLEAR;
					end
				end
			end
			ST_CLEAR: begin
				tab_we = 1'b1;
				if (i_q == goal_q) begin
					i_d     = '0;
					state_d = ST_OUTER;
				end else begin
					i_d = i_q + SUM_W'(1);
				end
			end
			ST_OUTER: begin
				state_d = (i_q == goal_q) ? ST_CHECK : ST_OUTER_RD;
			end
			ST_OUTER_RD: begin
				if (i_q != '0 && tab_rd_q == '0) begin
					i_d     = i_q + SUM_W'(1);
					state_d = ST_OUTER;
				end else begin
					j_d     = tab_rd_q + IDX_W'(1);
					state_d = ST_JLOOP;
				end
			end
			ST_JLOOP: begin
				if (j_q > n_q) begin
					i_d     = i_q + SUM_W'(1);
					state_d = ST_OUTER;
				end else begin
					state_d = ST_JVAL;
				end
			end
			ST_JVAL: begin
				if (v_rd_q == '0 || k_wide > (VAL_W+1)'(goal_q)) begin
					j_d     = j_q + IDX_W'(1);
					state_d = ST_JLOOP;
				end else begin
					k_d       = k_wide[SUM_W-1:0];
					tab_raddr = k_wide[TAB_AW-1:0];
					state_d   = ST_JTAB;
				end
			end
			ST_JTAB: begin
				if (tab_rd_q == '0 || tab_rd_q > j_q) begin
					tab_we    = 1'b1;
					tab_waddr = k_q[TAB_AW-1:0];
					tab_wdata = j_q;
				end
				j_d     = j_q + IDX_W'(1);
				state_d = ST_JLOOP;
			end
			ST_CHECK: begin
				tab_raddr = goal_q[TAB_AW-1:0];
				state_d   = ST_CHECK_RD;
			end
			ST_CHECK_RD: begin
				pend_d.chosen_index   = '0;
				pend_d.chosen_value   = '0;
				pend_d.is_last_result = 1'b1;
				if (goal_q == '0) begin
					pend_d.found = 1'b1;
					state_d      = ST_EMIT;
				end else if (tab_rd_q == '0) begin
					pend_d.found = 1'b0;
					state_d      = ST_EMIT;
				end else begin
					sum_d   = goal_q;
					state_d = ST_TRACE;
				end
			end
			ST_TRACE: begin
				tab_raddr = sum_q[TAB_AW-1:0];
				state_d   = ST_TR_IDX;
			end
			ST_TR_IDX: begin
				idx_d   = tab_rd_q;
				v_raddr = IDX_AW'(tab_rd_q - IDX_W'(1));
				state_d = ST_TR_VAL;
			end
			ST_TR_VAL: begin
				pend_d.found          = 1'b1;
				pend_d.chosen_index   = idx_q;
				pend_d.chosen_value   = v_rd_q;
				pend_d.is_last_result = (new_sum == '0);
				sum_d                 = new_sum;
				state_d               = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = pend_q.is_last_result ? ST_IDLE : ST_TRACE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!res_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		goal_q <= goal_d;
		n_q    <= n_d;
		i_q    <= i_d;
		j_q    <= j_d;
		k_q    <= k_d;
		sum_q  <= sum_d;
		idx_q  <= idx_d;
		pend_q <= pend_d;
		if (out_load) begin
			out_q <= pend_q;
		end
	end

endmodule

// File: hw/rtl/subset_sum_dp_traceback_top.sv
// ----------------------------------------------------------------------------
// subset_sum_dp_traceback_top
// load: one transaction per cycle while the 4-entry command queue has room
// run: clear pass over table entries 0..goal, then per reachable sum a scan
//   of its candidate indices up to n, then a read of the goal entry
// traceback: TRACE, TR_IDX, TR_VAL and EMIT per result, EMIT waits on stalls
// reset clears control state only; the sum table is swept at each run start
// ----------------------------------------------------------------------------
module subset_sum_dp_traceback_top #(
	parameter int MAX_ITEMS = 64,
	parameter int MAX_SUM   = 1023
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	output logic                       item_stall,
	input  ssdp_pkg::item_t            item_data,
	output logic                       res_valid,
	input  logic                       res_stall,
	output ssdp_pkg::res_t             res_data,
	input  logic                       cfg_we,
	input  logic [ssdp_pkg::SUM_W-1:0] cfg_data
);
	import ssdp_pkg::*;

	logic [SUM_W-1:0] target_q;
	logic             push;
	cmd_t             push_cmd;
	cmd_t             head;
	logic             q_empty;
	logic             q_full;
	logic             pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= SUM_W'(1);
		end else if (cfg_we) begin
			target_q <= cfg_data;
		end
	end

	ssdp_front #(
		.MAX_ITEMS(MAX_ITEMS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item_data (item_data),
		.q_full    (q_full),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	ssdp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.pop     (pop),
		.head    (head),
		.empty   (q_empty),
		.full    (q_full)
	);

	ssdp_back #(
		.MAX_ITEMS(MAX_ITEMS),
		.MAX_SUM  (MAX_SUM)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.target   (target_q),
		.head     (head),
		.q_empty  (q_empty),
		.pop      (pop),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_data (res_data)
	);

endmodule

// File: hw/rtl/ssdp_checker.sv
// ----------------------------------------------------------------------------
// ssdp_checker
// port-level checks of the subset sum engine, bound to the top level
// ----------------------------------------------------------------------------
`include "subset_sum_dp_traceback_top_assert.svh"

module ssdp_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       item_valid,
	input logic                       item_stall,
	input ssdp_pkg::item_t            item_data,
	input logic                       res_valid,
	input logic                       res_stall,
	input ssdp_pkg::res_t             res_data
);
	import ssdp_pkg::*;

	`SSDP_ASSERT_NOW(a_miss_is_last, clk, arst_n, res_valid && !res_data.found, res_data.is_last_result, "miss transaction not flagged last")

	`SSDP_ASSERT_NOW(a_miss_is_zero, clk, arst_n, res_valid && !res_data.found, res_data.chosen_index == '0 && res_data.chosen_value == '0, "miss transaction carries data")

	`SSDP_ASSERT_NOW(a_chosen_nonzero, clk, arst_n, res_valid && res_data.found && res_data.chosen_index != '0, res_data.chosen_value != '0, "zero value chosen")

	`SSDP_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && res_stall, res_valid && $stable(res_data), "stalled result transaction changed")

	`SSDP_ASSERT_NEXT(a_item_hold, clk, arst_n, item_valid && item_stall, item_valid && $stable(item_data), "stalled input transaction changed")

endmodule

bind subset_sum_dp_traceback_top ssdp_checker u_ssdp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.item_valid(item_valid),
	.item_stall(item_stall),
	.item_data (item_data),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res_data  (res_data)
);
